### design/dtq_pkg.sv
// Package with the shared types, codes and sizes of the delta timer event queue.
`default_nettype none
package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DELTA_W = 16;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_STORED = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [7:0] device;
    logic [7:0] callback;
    logic [31:0] arg_tag;
    logic signed [31:0] int_arg;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SET_DELTA,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    idx_t pos;
    entry_t ent;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WALK,
    ST_ADD_INS,
    ST_CAN_WALK,
    ST_CAN_SUM,
    ST_CAN_DEL,
    ST_TICK_DEC,
    ST_TICK_FIRE
  } state_t;

endpackage
`default_nettype wire

### design/delta_timer_event_queue.sv
// Top level of the delta timer event queue: command sequencer, row of cells and result register.
// An add with zero delay fires at once and one to a full queue is rejected; any other add
// walks the stored entries one per cycle and then inserts the new entry. A cancel walks them
// to the first matching entry, folds its delta into the next entry if any and removes it.
// A tick decrements the head delta and then fires each leading entry whose delta is zero.
// A result that waits for out_ready holds the block. A single walker compares one cell per
// cycle, and an item is accepted only when the block is idle and its result register is free.
`default_nettype none
module delta_timer_event_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [7:0]         in_device_id,
  input  wire logic [7:0]         in_callback_id,
  input  wire logic [15:0]        in_delay,
  input  wire logic [31:0]        in_arg_tag,
  input  wire logic signed [31:0] in_int_arg,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_device,
  output logic [7:0]              out_callback,
  output logic [31:0]             out_arg_tag,
  output logic signed [31:0]      out_int_arg,
  output logic                    out_last
);

  localparam int DEPTH = dtq_pkg::QUEUE_DEPTH;
  localparam int IDX_W = dtq_pkg::IDX_W;
  localparam int CNT_W = dtq_pkg::CNT_W;
  localparam int DW = dtq_pkg::DELTA_W;

  dtq_pkg::state_t state_r, state_nxt;
  dtq_pkg::cnt_t count_r, count_nxt;
  dtq_pkg::cnt_t walk_r, walk_nxt;
  dtq_pkg::idx_t pos_r, pos_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] hold_d_r, hold_d_nxt;
  logic [7:0] dev_r, dev_nxt;
  logic [7:0] cb_r, cb_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic signed [31:0] iarg_r, iarg_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_device_r, out_device_nxt;
  logic [7:0] out_callback_r, out_callback_nxt;
  logic [31:0] out_arg_tag_r, out_arg_tag_nxt;
  logic signed [31:0] out_int_arg_r, out_int_arg_nxt;
  logic out_last_r, out_last_nxt;

  dtq_pkg::cell_ctl_t ctl;
  dtq_pkg::entry_t cells [DEPTH];
  dtq_pkg::entry_t rd_ent;
  dtq_pkg::cnt_t walk_inc;
  logic [DW:0] sum;
  logic out_free;
  logic in_fire;
  logic fire_last;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      dtq_pkg::entry_t prev_ent;
      dtq_pkg::entry_t next_ent;
      if (g == 0) begin : g_first
        assign prev_ent = cells[0];
      end else begin : g_mid
        assign prev_ent = cells[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
        assign next_ent = cells[DEPTH-1];
      end else begin : g_rest
        assign next_ent = cells[g+1];
      end
      dtq_cell u_cell (
        .clk      (clk),
        .idx      (IDX_W'(g)),
        .ctl      (ctl),
        .prev_ent (prev_ent),
        .next_ent (next_ent),
        .ent      (cells[g])
      );
    end
  endgenerate

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == dtq_pkg::ST_IDLE) && out_free;
  assign in_fire = in_valid && in_ready;
  assign rd_ent = cells[walk_r[IDX_W-1:0]];
  assign walk_inc = walk_r + CNT_W'(1);
  assign sum = {1'b0, rd_ent.delta} + {1'b0, hold_d_r};
  assign fire_last = (count_r == CNT_W'(1)) || (cells[1].delta != '0);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    walk_nxt = walk_r;
    pos_nxt = pos_r;
    rem_nxt = rem_r;
    hold_d_nxt = hold_d_r;
    dev_nxt = dev_r;
    cb_nxt = cb_r;
    tag_nxt = tag_r;
    iarg_nxt = iarg_r;
    ctl.op = dtq_pkg::CELL_HOLD;
    ctl.pos = pos_r;
    ctl.ent = '{delta: rem_r, device: dev_r, callback: cb_r, arg_tag: tag_r, int_arg: iarg_r};
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt = out_kind_r;
    out_device_nxt = out_device_r;
    out_callback_nxt = out_callback_r;
    out_arg_tag_nxt = out_arg_tag_r;
    out_int_arg_nxt = out_int_arg_r;
    out_last_nxt = out_last_r;

    unique case (state_r)
      dtq_pkg::ST_IDLE: begin
        if (in_fire) begin
          dev_nxt = in_device_id;
          cb_nxt = in_callback_id;
          tag_nxt = in_arg_tag;
          iarg_nxt = in_int_arg;
          rem_nxt = in_delay;
          walk_nxt = '0;
          priority if (in_cmd == dtq_pkg::CMD_ADD) begin
            out_valid_nxt = 1'b1;
            out_device_nxt = in_device_id;
            out_callback_nxt = in_callback_id;
            out_last_nxt = 1'b1;
            if (in_delay == '0) begin
              out_kind_nxt = dtq_pkg::KIND_FIRE;
              out_arg_tag_nxt = in_arg_tag;
              out_int_arg_nxt = in_int_arg;
            end else if (count_r == CNT_W'(DEPTH)) begin
              out_kind_nxt = dtq_pkg::KIND_FULL;
              out_arg_tag_nxt = '0;
              out_int_arg_nxt = '0;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt = dtq_pkg::ST_ADD_WALK;
            end
          end else if (in_cmd == dtq_pkg::CMD_CANCEL) begin
            if (count_r != '0) begin
              state_nxt = dtq_pkg::ST_CAN_WALK;
            end
          end else if (in_cmd == dtq_pkg::CMD_TICK) begin
            if (count_r != '0) begin
              state_nxt = dtq_pkg::ST_TICK_DEC;
            end
          end else begin
            state_nxt = dtq_pkg::ST_IDLE;
          end
        end
      end
      dtq_pkg::ST_ADD_WALK: begin
        if (walk_r == count_r) begin
          pos_nxt = walk_r[IDX_W-1:0];
          state_nxt = dtq_pkg::ST_ADD_INS;
        end else if (rem_r <= rd_ent.delta) begin
          ctl.op = dtq_pkg::CELL_SET_DELTA;
          ctl.pos = walk_r[IDX_W-1:0];
          ctl.ent.delta = rd_ent.delta - rem_r;
          pos_nxt = walk_r[IDX_W-1:0];
          state_nxt = dtq_pkg::ST_ADD_INS;
        end else begin
          rem_nxt = rem_r - rd_ent.delta;
          walk_nxt = walk_inc;
        end
      end
      dtq_pkg::ST_ADD_INS: begin
        if (out_free) begin
          ctl.op = dtq_pkg::CELL_INSERT;
          count_nxt = count_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_kind_nxt = dtq_pkg::KIND_STORED;
          out_device_nxt = dev_r;
          out_callback_nxt = cb_r;
          out_arg_tag_nxt = '0;
          out_int_arg_nxt = '0;
          out_last_nxt = 1'b1;
          state_nxt = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_CAN_WALK: begin
        if (walk_r == count_r) begin
          state_nxt = dtq_pkg::ST_IDLE;
        end else if (rd_ent.device == dev_r && rd_ent.callback == cb_r) begin
          pos_nxt = walk_r[IDX_W-1:0];
          hold_d_nxt = rd_ent.delta;
          if (walk_inc < count_r) begin
            walk_nxt = walk_inc;
            state_nxt = dtq_pkg::ST_CAN_SUM;
          end else begin
            state_nxt = dtq_pkg::ST_CAN_DEL;
          end
        end else begin
          walk_nxt = walk_inc;
        end
      end
      dtq_pkg::ST_CAN_SUM: begin
        ctl.op = dtq_pkg::CELL_SET_DELTA;
        ctl.pos = walk_r[IDX_W-1:0];
        ctl.ent.delta = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
        state_nxt = dtq_pkg::ST_CAN_DEL;
      end
      dtq_pkg::ST_CAN_DEL: begin
        ctl.op = dtq_pkg::CELL_REMOVE;
        ctl.pos = pos_r;
        count_nxt = count_r - CNT_W'(1);
        state_nxt = dtq_pkg::ST_IDLE;
      end
      dtq_pkg::ST_TICK_DEC: begin
        ctl.op = dtq_pkg::CELL_SET_DELTA;
        ctl.pos = '0;
        ctl.ent.delta = cells[0].delta - DW'(1);
        state_nxt = dtq_pkg::ST_TICK_FIRE;
      end
      dtq_pkg::ST_TICK_FIRE: begin
        if (cells[0].delta != '0) begin
          state_nxt = dtq_pkg::ST_IDLE;
        end else if (out_free) begin
          ctl.op = dtq_pkg::CELL_REMOVE;
          ctl.pos = '0;
          count_nxt = count_r - CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_kind_nxt = dtq_pkg::KIND_FIRE;
          out_device_nxt = cells[0].device;
          out_callback_nxt = cells[0].callback;
          out_arg_tag_nxt = cells[0].arg_tag;
          out_int_arg_nxt = cells[0].int_arg;
          out_last_nxt = fire_last;
          if (fire_last) begin
            state_nxt = dtq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dtq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtq_pkg::ST_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
    pos_r <= pos_nxt;
    rem_r <= rem_nxt;
    hold_d_r <= hold_d_nxt;
    dev_r <= dev_nxt;
    cb_r <= cb_nxt;
    tag_r <= tag_nxt;
    iarg_r <= iarg_nxt;
    out_kind_r <= out_kind_nxt;
    out_device_r <= out_device_nxt;
    out_callback_r <= out_callback_nxt;
    out_arg_tag_r <= out_arg_tag_nxt;
    out_int_arg_r <= out_int_arg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_device = out_device_r;
  assign out_callback = out_callback_r;
  assign out_arg_tag = out_arg_tag_r;
  assign out_int_arg = out_int_arg_r;
  assign out_last = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtq_pkg::ST_ADD_INS && out_free) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("A stored add did not grow the queue by one.");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtq_pkg::ST_CAN_DEL || state_r == dtq_pkg::ST_TICK_FIRE) |-> count_r != '0)
    else $error("An entry is removed from an empty queue.");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dtq_pkg::ST_IDLE) |-> !in_ready)
    else $error("An item is taken while a command is still in progress.");

endmodule
`default_nettype wire

### design/dtq_cell.sv
// One queue cell: holds one entry and moves it to or from its neighbors on command.
`default_nettype none
module dtq_cell (
  input  wire logic              clk,
  input  wire dtq_pkg::idx_t     idx,
  input  wire dtq_pkg::cell_ctl_t ctl,
  input  wire dtq_pkg::entry_t   prev_ent,
  input  wire dtq_pkg::entry_t   next_ent,
  output dtq_pkg::entry_t        ent
);

  dtq_pkg::entry_t ent_r;
  dtq_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl.op)
      dtq_pkg::CELL_SET_DELTA: begin
        if (idx == ctl.pos) begin
          ent_nxt.delta = ctl.ent.delta;
        end
      end
      dtq_pkg::CELL_INSERT: begin
        if (idx == ctl.pos) begin
          ent_nxt = ctl.ent;
        end else if (idx > ctl.pos) begin
          ent_nxt = prev_ent;
        end
      end
      dtq_pkg::CELL_REMOVE: begin
        if (idx >= ctl.pos) begin
          ent_nxt = next_ent;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

### test/tb_delta_timer_event_queue.sv
// Self-checking testbench for the delta timer event queue with its own queue predictor.
`timescale 1ns / 100ps
module tb_delta_timer_event_queue;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTED = 20;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] device;
    logic [7:0] callback;
    logic [31:0] arg_tag;
    logic signed [31:0] int_arg;
    logic last;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = dtq_pkg::CMD_ADD;
  logic [7:0] in_device_id = 8'd0;
  logic [7:0] in_callback_id = 8'd0;
  logic [15:0] in_delay = 16'd0;
  logic [31:0] in_arg_tag = 32'd0;
  logic signed [31:0] in_int_arg = 32'sd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_device;
  logic [7:0] out_callback;
  logic [31:0] out_arg_tag;
  logic signed [31:0] out_int_arg;
  logic out_last;

  dtq_pkg::entry_t timer_list[dtq_pkg::QUEUE_DEPTH];
  int list_len = 0;
  timer_result_t awaited_results[$];
  int err_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit gaps_on = 1'b1;
  int n_fired = 0;
  int n_stored = 0;
  int n_rejected = 0;
  int n_cancels = 0;
  int n_ticks = 0;
  int n_checked = 0;

  delta_timer_event_queue u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_device_id(in_device_id),
    .in_callback_id(in_callback_id),
    .in_delay(in_delay),
    .in_arg_tag(in_arg_tag),
    .in_int_arg(in_int_arg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_device(out_device),
    .out_callback(out_callback),
    .out_arg_tag(out_arg_tag),
    .out_int_arg(out_int_arg),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               awaited_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
  endtask

  function automatic void await_result(input logic [1:0] kind, input logic [7:0] dev,
                                       input logic [7:0] cb, input logic [31:0] tag,
                                       input logic signed [31:0] iarg, input logic fin);
    timer_result_t r;
    r.kind = kind;
    r.device = dev;
    r.callback = cb;
    r.arg_tag = tag;
    r.int_arg = iarg;
    r.last = fin;
    awaited_results.push_back(r);
    case (kind)
      dtq_pkg::KIND_FIRE: n_fired++;
      dtq_pkg::KIND_STORED: n_stored++;
      default: n_rejected++;
    endcase
  endfunction

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < list_len; i++) begin
      timer_list[i] = timer_list[i + 1];
    end
    list_len--;
  endfunction

  function automatic void predict_timer_cmd(input logic [1:0] cmd, input logic [7:0] dev,
                                            input logic [7:0] cb, input logic [15:0] dly,
                                            input logic [31:0] tag,
                                            input logic signed [31:0] iarg);
    int pos;
    int fired;
    bit found;
    logic [15:0] rest;
    logic [16:0] sum;
    dtq_pkg::entry_t head;
    pos = list_len;
    fired = 0;
    found = 1'b0;
    rest = dly;
    case (cmd)
      dtq_pkg::CMD_ADD: begin
        if (dly == 16'd0) begin
          await_result(dtq_pkg::KIND_FIRE, dev, cb, tag, iarg, 1'b1);
        end else if (list_len >= dtq_pkg::QUEUE_DEPTH) begin
          await_result(dtq_pkg::KIND_FULL, dev, cb, 32'd0, 32'sd0, 1'b1);
        end else begin
          for (int i = 0; i < list_len && !found; i++) begin
            if (rest <= timer_list[i].delta) begin
              timer_list[i].delta = timer_list[i].delta - rest;
              pos = i;
              found = 1'b1;
            end else begin
              rest = rest - timer_list[i].delta;
            end
          end
          for (int i = list_len; i > pos; i--) begin
            timer_list[i] = timer_list[i - 1];
          end
          timer_list[pos].delta = rest;
          timer_list[pos].device = dev;
          timer_list[pos].callback = cb;
          timer_list[pos].arg_tag = tag;
          timer_list[pos].int_arg = iarg;
          list_len++;
          await_result(dtq_pkg::KIND_STORED, dev, cb, 32'd0, 32'sd0, 1'b1);
        end
      end
      dtq_pkg::CMD_CANCEL: begin
        n_cancels++;
        for (int i = 0; i < list_len && !found; i++) begin
          if (timer_list[i].device == dev && timer_list[i].callback == cb) begin
            if (i + 1 < list_len) begin
              sum = {1'b0, timer_list[i + 1].delta} + {1'b0, timer_list[i].delta};
              timer_list[i + 1].delta = sum[16] ? 16'hFFFF : sum[15:0];
            end
            drop_entry(i);
            found = 1'b1;
          end
        end
      end
      dtq_pkg::CMD_TICK: begin
        n_ticks++;
        if (list_len > 0) begin
          timer_list[0].delta = timer_list[0].delta - 16'd1;
          while (list_len > 0 && timer_list[0].delta == 16'd0 &&
                 fired < dtq_pkg::QUEUE_DEPTH) begin
            head = timer_list[0];
            drop_entry(0);
            fired++;
            await_result(dtq_pkg::KIND_FIRE, head.device, head.callback, head.arg_tag,
                         head.int_arg,
                         !(list_len > 0 && timer_list[0].delta == 16'd0 &&
                           fired < dtq_pkg::QUEUE_DEPTH));
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] dev, input logic [7:0] cb,
                          input logic [15:0] dly, input logic [31:0] tag,
                          input logic signed [31:0] iarg);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_device_id <= dev;
    in_callback_id <= cb;
    in_delay <= dly;
    in_arg_tag <= tag;
    in_int_arg <= iarg;
    do @(posedge clk); while (!in_ready);
    predict_timer_cmd(cmd, dev, cb, dly, tag, iarg);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() > 0);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    out_ready <= (stall_left == 0);
  end

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d device %0d callback %0d",
                                  out_kind, out_device, out_callback));
      end else begin
        want = awaited_results.pop_front();
        n_checked++;
        compare_field("kind", 32'(out_kind), 32'(want.kind));
        compare_field("device", 32'(out_device), 32'(want.device));
        compare_field("callback", 32'(out_callback), 32'(want.callback));
        compare_field("arg_tag", out_arg_tag, want.arg_tag);
        compare_field("int_arg", out_int_arg, want.int_arg);
        compare_field("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  task automatic test_immediate_fire();
    send_cmd(dtq_pkg::CMD_ADD, 8'hFF, 8'h00, 16'd0, 32'hFFFF_FFFF, 32'sh8000_0000);
    send_cmd(dtq_pkg::CMD_ADD, 8'h00, 8'hFF, 16'd0, 32'h0000_0000, 32'sh7FFF_FFFF);
  endtask

  task automatic test_ordering_and_cancel();
    send_cmd(dtq_pkg::CMD_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 32'sd0);
    send_cmd(dtq_pkg::CMD_CANCEL, 8'd1, 8'd1, 16'd0, 32'd0, 32'sd0);
    send_cmd(dtq_pkg::CMD_ADD, 8'd1, 8'd1, 16'd3, $urandom, $urandom);
    send_cmd(dtq_pkg::CMD_ADD, 8'd2, 8'd2, 16'd1, $urandom, $urandom);
    send_cmd(dtq_pkg::CMD_ADD, 8'd3, 8'd3, 16'd1, $urandom, $urandom);
    send_cmd(dtq_pkg::CMD_ADD, 8'd4, 8'd4, 16'hFFFF, $urandom, $urandom);
    send_cmd(dtq_pkg::CMD_CANCEL, 8'd9, 8'd9, 16'd0, 32'd0, 32'sd0);
    send_cmd(dtq_pkg::CMD_CANCEL, 8'd1, 8'd2, 16'd0, 32'd0, 32'sd0);
    send_cmd(dtq_pkg::CMD_CANCEL, 8'd1, 8'd1, 16'd0, 32'd0, 32'sd0);
    send_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, -32'sd1);
    send_cmd(dtq_pkg::CMD_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 32'sd0);
    send_cmd(dtq_pkg::CMD_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 32'sd0);
    send_cmd(dtq_pkg::CMD_CANCEL, 8'd4, 8'd4, 16'd0, 32'd0, 32'sd0);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < dtq_pkg::QUEUE_DEPTH; i++) begin
      send_cmd(dtq_pkg::CMD_ADD, 8'(i * 17), 8'(255 - i * 17), 16'd1, $urandom, $urandom);
    end
    send_cmd(dtq_pkg::CMD_ADD, 8'hAA, 8'h55, 16'd7, $urandom, $urandom);
    send_cmd(dtq_pkg::CMD_ADD, 8'h55, 8'hAA, 16'd0, $urandom, $urandom);
    send_cmd(dtq_pkg::CMD_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 32'sd0);
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    int idx;
    logic [1:0] cmd;
    logic [7:0] dev;
    logic [7:0] cb;
    logic [15:0] dly;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      dev = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      cb = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      idx = $urandom_range(0, 19);
      if (idx == 0) begin
        dly = 16'd0;
      end else if (idx <= 2) begin
        dly = 16'($urandom);
      end else begin
        dly = 16'($urandom_range(1, 6));
      end
      if (pick < 40) begin
        cmd = dtq_pkg::CMD_ADD;
      end else if (pick < 60) begin
        cmd = dtq_pkg::CMD_CANCEL;
        if (list_len > 0 && $urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, list_len - 1);
          dev = timer_list[idx].device;
          cb = timer_list[idx].callback;
        end
      end else if (pick < 96) begin
        cmd = dtq_pkg::CMD_TICK;
      end else begin
        cmd = CMD_UNUSED;
      end
      send_cmd(cmd, dev, cb, dly, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_immediate_fire();
    test_ordering_and_cancel();
    test_full_queue();
    test_random_traffic(90);
    drain_results();
    test_random_traffic(90);
    gaps_on = 1'b0;
    test_random_traffic(45);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d ticks and %0d cancels; checked %0d results.", n_ticks, n_cancels,
             n_checked);
    $display("Results seen: %0d fired, %0d stored, %0d rejected on a full queue.", n_fired,
             n_stored, n_rejected);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
design/dtq_pkg.sv
design/dtq_cell.sv
design/delta_timer_event_queue.sv
test/tb_delta_timer_event_queue.sv
